/* rtl/stok_pkg.sv */
// ----------------------------------------------------------------------------
// stok_pkg
// Shared types, token kinds, keyword table and byte helpers for the tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

  localparam int OFFSET_BITS_DEF     = 24;
  localparam int LINE_BITS_DEF       = 16;
  localparam int KEYWORD_MAX_LEN_DEF = 10;

  localparam int KIND_W   = 6;
  localparam int KW_COUNT = 19;
  localparam int KW_CHARS = 10;
  localparam int QUEUE_DEPTH = 4;

  // Token kinds
  localparam logic [KIND_W-1:0] KIND_IDENT    = 6'd19;
  localparam logic [KIND_W-1:0] KIND_INT      = 6'd20;
  localparam logic [KIND_W-1:0] KIND_DEC      = 6'd21;
  localparam logic [KIND_W-1:0] KIND_STR      = 6'd22;
  localparam logic [KIND_W-1:0] KIND_PLUS     = 6'd23;
  localparam logic [KIND_W-1:0] KIND_MINUS    = 6'd24;
  localparam logic [KIND_W-1:0] KIND_STAR     = 6'd25;
  localparam logic [KIND_W-1:0] KIND_SLASH    = 6'd26;
  localparam logic [KIND_W-1:0] KIND_PERCENT  = 6'd27;
  localparam logic [KIND_W-1:0] KIND_ASSIGN   = 6'd28;
  localparam logic [KIND_W-1:0] KIND_LT       = 6'd29;
  localparam logic [KIND_W-1:0] KIND_GT       = 6'd30;
  localparam logic [KIND_W-1:0] KIND_COLON    = 6'd31;
  localparam logic [KIND_W-1:0] KIND_COMMA    = 6'd32;
  localparam logic [KIND_W-1:0] KIND_LPAREN   = 6'd33;
  localparam logic [KIND_W-1:0] KIND_RPAREN   = 6'd34;
  localparam logic [KIND_W-1:0] KIND_LBRACE   = 6'd35;
  localparam logic [KIND_W-1:0] KIND_RBRACE   = 6'd36;
  localparam logic [KIND_W-1:0] KIND_EQ       = 6'd37;
  localparam logic [KIND_W-1:0] KIND_NE       = 6'd38;
  localparam logic [KIND_W-1:0] KIND_LE       = 6'd39;
  localparam logic [KIND_W-1:0] KIND_GE       = 6'd40;
  localparam logic [KIND_W-1:0] KIND_ERR      = 6'd41;
  localparam logic [KIND_W-1:0] KIND_EOF      = 6'd42;
  localparam logic [KIND_W-1:0] KIND_OPEN_STR = 6'd43;
  localparam logic [KIND_W-1:0] KIND_AND      = 6'd16;
  localparam logic [KIND_W-1:0] KIND_OR       = 6'd17;

  // Keywords, space padded to KW_CHARS, first character in the top byte
  localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
    "inicio    ", "var       ", "def       ", "retorna   ", "se        ",
    "senao     ", "enquanto  ", "para      ", "escreve   ", "le        ",
    "inteiro   ", "decimal   ", "texto     ", "logico    ", "verdadeiro",
    "falso     ", "e         ", "ou        ", "nao       "
  };
  localparam int KW_LEN [KW_COUNT] = '{
    6, 3, 3, 7, 2, 5, 8, 4, 7, 2, 7, 7, 5, 6, 10, 5, 1, 2, 3
  };

  // Byte classes worked out at the input side
  typedef struct packed {
    logic                is_space;
    logic                is_newline;
    logic                is_digit;
    logic                is_alpha;
    logic                is_quote;
    logic                is_bslash;
    logic                is_dot;
    logic                may_pair;
    logic [KIND_W-1:0]   single;
  } byte_class_t;

  typedef struct packed {
    logic [7:0]   data;
    logic         eoi;
    byte_class_t  cls;
  } beat_t;

  function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2A:   k = KIND_STAR;
      8'h2F:   k = KIND_SLASH;
      8'h25:   k = KIND_PERCENT;
      8'h3D:   k = KIND_ASSIGN;
      8'h3C:   k = KIND_LT;
      8'h3E:   k = KIND_GT;
      8'h3A:   k = KIND_COLON;
      8'h2C:   k = KIND_COMMA;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      default: k = KIND_ERR;
    endcase
    return k;
  endfunction

  // Two-character operator kind; valid flag in the top bit
  function automatic logic [KIND_W:0] pair_kind(input logic [7:0] c, input logic [7:0] b);
    logic [KIND_W:0] r;
    r = '0;
    if (b == "=") begin
      if (c == "=") r = {1'b1, KIND_EQ};
      if (c == "!") r = {1'b1, KIND_NE};
      if (c == "<") r = {1'b1, KIND_LE};
      if (c == ">") r = {1'b1, KIND_GE};
    end
    if (c == "&" && b == "&") r = {1'b1, KIND_AND};
    if (c == "|" && b == "|") r = {1'b1, KIND_OR};
    return r;
  endfunction

endpackage

/* rtl/stok_front.sv */
// ----------------------------------------------------------------------------
// stok_front
// Classifies each source byte and holds the beats in a short queue.
// ----------------------------------------------------------------------------
module stok_front import stok_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_value_i,
  input  logic        end_of_input_i,
  output logic        beat_valid_o,
  output beat_t       beat_o,
  input  logic        beat_pop_i
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  beat_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   cnt_q;
  byte_class_t        cls;
  logic               push, pop;

  // Classify the incoming byte
  always_comb begin
    cls            = '0;
    cls.is_newline = (byte_value_i == 8'h0A);
    cls.is_space   = (byte_value_i == 8'h20) || (byte_value_i == 8'h09) ||
                     (byte_value_i == 8'h0D) || cls.is_newline;
    cls.is_digit   = (byte_value_i >= "0") && (byte_value_i <= "9");
    cls.is_alpha   = ((byte_value_i >= "a") && (byte_value_i <= "z")) ||
                     ((byte_value_i >= "A") && (byte_value_i <= "Z")) ||
                     (byte_value_i == "_");
    cls.is_quote   = (byte_value_i == 8'h22);
    cls.is_bslash  = (byte_value_i == 8'h5C);
    cls.is_dot     = (byte_value_i == ".");
    cls.may_pair   = (byte_value_i == "=") || (byte_value_i == "!") ||
                     (byte_value_i == "<") || (byte_value_i == ">") ||
                     (byte_value_i == "&") || (byte_value_i == "|") ||
                     (byte_value_i == "/");
    cls.single     = single_kind(byte_value_i);
  end

  assign in_stall_o   = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign push         = in_valid_i && !in_stall_o;
  assign beat_valid_o = (cnt_q != '0);
  assign pop          = beat_pop_i && beat_valid_o;
  assign beat_o       = mem_q[rd_q];

  // Store accepted beats
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{data: byte_value_i, eoi: end_of_input_i, cls: cls};
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + PTR_W'(1);
      if (pop)  rd_q <= rd_q + PTR_W'(1);
      if (push && !pop)      cnt_q <= cnt_q + CNT_W'(1);
      else if (pop && !push) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

endmodule

/* rtl/stok_back.sv */
// ----------------------------------------------------------------------------
// stok_back
// Scan engine: tracks position and scan mode, builds tokens, drives the
// output register. A two-token beat is popped only with its second token.
// ----------------------------------------------------------------------------
module stok_back import stok_pkg::*; #(
  parameter int OFFSET_BITS     = OFFSET_BITS_DEF,
  parameter int LINE_BITS       = LINE_BITS_DEF,
  parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   beat_valid_i,
  input  beat_t                  beat_i,
  output logic                   beat_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [KIND_W-1:0]      token_kind_o,
  output logic [OFFSET_BITS-1:0] start_offset_o,
  output logic [OFFSET_BITS-1:0] token_length_o,
  output logic [LINE_BITS-1:0]   start_line_o,
  output logic [LINE_BITS-1:0]   start_column_o,
  output logic                   last_of_run_o
);

  localparam int IDX_W = $clog2(KEYWORD_MAX_LEN);
  localparam int CNT_W = $clog2(KEYWORD_MAX_LEN + 1);
  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

  typedef enum logic [7:0] {
    M_IDLE = 8'b0000_0001,
    M_INT  = 8'b0000_0010,
    M_FRAC = 8'b0000_0100,
    M_WORD = 8'b0000_1000,
    M_STR  = 8'b0001_0000,
    M_ESC  = 8'b0010_0000,
    M_CMT  = 8'b0100_0000,
    M_OP   = 8'b1000_0000
  } mode_e;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [OFFSET_BITS-1:0] off;
    logic [OFFSET_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic [LINE_BITS-1:0]   col;
  } token_t;

  mode_e                  mode_q, mode_d;
  logic [OFFSET_BITS-1:0] off_q, off_d, ts_off_q, ts_off_d;
  logic [LINE_BITS-1:0]   line_q, line_d, col_q, col_d;
  logic [LINE_BITS-1:0]   ts_line_q, ts_line_d, ts_col_q, ts_col_d;
  logic [7:0]             wbuf_q [KEYWORD_MAX_LEN];
  logic [CNT_W-1:0]       wcnt_q, wcnt_d;
  logic                   wlong_q, wlong_d;
  logic                   wwr;
  logic [IDX_W-1:0]       widx;
  logic [7:0]             pend_q, pend_d;
  logic                   phase_q;
  logic                   out_v_q;
  token_t                 out_q;
  logic                   last_q;

  logic [KIND_W-1:0]      wkind;
  logic [OFFSET_BITS-1:0] span;
  token_t                 tk0, tk1, tkn;
  logic [1:0]             ntok;
  logic                   consumed, opened, hit;
  logic [KIND_W:0]        pk;
  logic                   can_out, commit;

  // Match the stored word against the keyword list
  always_comb begin
    wkind = KIND_IDENT;
    hit   = 1'b0;
    if (!wlong_q) begin
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
        hit = (int'(wcnt_q) == KW_LEN[k]);
        for (int i = 0; i < KW_CHARS; i++) begin
          if (i < KW_LEN[k] && wbuf_q[i] != KW_TEXT[k][8*(KW_CHARS-i)-1 -: 8]) hit = 1'b0;
        end
        if (hit) wkind = KIND_W'(k);
      end
    end
  end

  assign span = off_q - ts_off_q;
  assign pk   = pair_kind(pend_q, beat_i.data);

  // Next state and tokens for the head beat
  always_comb begin
    mode_d    = mode_q;
    off_d     = off_q;
    line_d    = line_q;
    col_d     = col_q;
    ts_off_d  = ts_off_q;
    ts_line_d = ts_line_q;
    ts_col_d  = ts_col_q;
    wcnt_d    = wcnt_q;
    wlong_d   = wlong_q;
    wwr       = 1'b0;
    widx      = wcnt_q[IDX_W-1:0];
    pend_d    = pend_q;
    consumed  = 1'b0;
    opened    = 1'b0;
    ntok      = 2'd0;
    tk0       = '0;
    tk1       = '0;
    tkn       = '{kind: KIND_ERR, off: ts_off_q, len: span, line: ts_line_q, col: ts_col_q};

    if (beat_i.eoi) begin
      // Flush the pending token, then end of file
      case (mode_q)
        M_INT:         begin tkn.kind = KIND_INT;      ntok = 2'd1; end
        M_FRAC:        begin tkn.kind = KIND_DEC;      ntok = 2'd1; end
        M_WORD:        begin tkn.kind = wkind;         ntok = 2'd1; end
        M_STR, M_ESC:  begin tkn.kind = KIND_OPEN_STR; ntok = 2'd1; end
        M_OP: begin
          tkn.kind = single_kind(pend_q);
          tkn.len  = OFFSET_BITS'(1);
          ntok     = 2'd1;
        end
        default: ;
      endcase
      if (ntok == 2'd1) begin
        tk0 = tkn;
        tk1 = '{kind: KIND_EOF, off: off_q, len: '0, line: line_q, col: col_q};
        ntok = 2'd2;
      end else begin
        tk0 = '{kind: KIND_EOF, off: off_q, len: '0, line: line_q, col: col_q};
        ntok = 2'd1;
      end
      mode_d = M_IDLE;
    end else begin
      // Continue the token in progress
      case (mode_q)
        M_INT: begin
          if (beat_i.cls.is_digit) consumed = 1'b1;
          else if (beat_i.cls.is_dot) begin
            mode_d   = M_FRAC;
            consumed = 1'b1;
          end else begin
            tkn.kind = KIND_INT;
            ntok     = 2'd1;
            mode_d   = M_IDLE;
          end
        end
        M_FRAC: begin
          if (beat_i.cls.is_digit) consumed = 1'b1;
          else begin
            tkn.kind = KIND_DEC;
            ntok     = 2'd1;
            mode_d   = M_IDLE;
          end
        end
        M_WORD: begin
          if (beat_i.cls.is_alpha || beat_i.cls.is_digit) begin
            consumed = 1'b1;
            if (int'(wcnt_q) < KEYWORD_MAX_LEN) begin
              wwr    = 1'b1;
              wcnt_d = wcnt_q + CNT_W'(1);
            end else begin
              wlong_d = 1'b1;
            end
          end else begin
            tkn.kind = wkind;
            ntok     = 2'd1;
            mode_d   = M_IDLE;
          end
        end
        M_STR: begin
          consumed = 1'b1;
          if (beat_i.cls.is_quote) begin
            tkn.kind = KIND_STR;
            ntok     = 2'd1;
            mode_d   = M_IDLE;
          end else if (beat_i.cls.is_bslash) begin
            mode_d = M_ESC;
          end
        end
        M_ESC: begin
          consumed = 1'b1;
          mode_d   = M_STR;
        end
        M_CMT: begin
          consumed = 1'b1;
          if (beat_i.cls.is_newline) mode_d = M_IDLE;
        end
        M_OP: begin
          if (pk[KIND_W]) begin
            tkn.kind = pk[KIND_W-1:0];
            tkn.len  = OFFSET_BITS'(2);
            ntok     = 2'd1;
            mode_d   = M_IDLE;
            consumed = 1'b1;
          end else if (pend_q == "/" && beat_i.data == "/") begin
            mode_d   = M_CMT;
            consumed = 1'b1;
          end else begin
            tkn.kind = single_kind(pend_q);
            tkn.len  = OFFSET_BITS'(1);
            ntok     = 2'd1;
            mode_d   = M_IDLE;
          end
        end
        default: mode_d = M_IDLE;
      endcase
      tk0 = tkn;

      // Start a new token from this byte
      if (!consumed) begin
        if (beat_i.cls.is_space) begin
          // skip whitespace
        end else if (beat_i.cls.is_digit) begin
          ts_off_d  = off_q;
          ts_line_d = line_q;
          ts_col_d  = col_q;
          mode_d    = M_INT;
        end else if (beat_i.cls.is_alpha) begin
          ts_off_d  = off_q;
          ts_line_d = line_q;
          ts_col_d  = col_q;
          wwr       = 1'b1;
          widx      = '0;
          wcnt_d    = CNT_W'(1);
          wlong_d   = 1'b0;
          mode_d    = M_WORD;
        end else if (beat_i.cls.is_quote) begin
          opened = 1'b1;
        end else if (beat_i.cls.may_pair) begin
          ts_off_d  = off_q;
          ts_line_d = line_q;
          ts_col_d  = col_q;
          pend_d    = beat_i.data;
          mode_d    = M_OP;
        end else begin
          tkn = '{kind: beat_i.cls.single, off: off_q, len: OFFSET_BITS'(1),
                  line: line_q, col: col_q};
          if (ntok == 2'd0) tk0 = tkn;
          else tk1 = tkn;
          ntok = ntok + 2'd1;
        end
      end

      // Advance position over the byte
      if (off_q != OFF_MAX) off_d = off_q + OFFSET_BITS'(1);
      if (beat_i.cls.is_newline) begin
        if (line_q != LINE_MAX) line_d = line_q + LINE_BITS'(1);
        col_d = LINE_BITS'(1);
      end else if (col_q != LINE_MAX) begin
        col_d = col_q + LINE_BITS'(1);
      end

      // String content starts after the quote
      if (opened) begin
        ts_off_d  = off_d;
        ts_line_d = line_d;
        ts_col_d  = col_d;
        mode_d    = M_STR;
      end
    end
  end

  // Two-token beats pop only on the pass that loads the second token (phase_q)
  assign can_out    = !out_v_q || !out_stall_i;
  assign commit     = beat_valid_i && can_out && ((ntok != 2'd2) || phase_q);
  assign beat_pop_o = commit;

  // Hold scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= M_IDLE;
      off_q     <= '0;
      line_q    <= LINE_BITS'(1);
      col_q     <= LINE_BITS'(1);
      ts_off_q  <= '0;
      ts_line_q <= LINE_BITS'(1);
      ts_col_q  <= LINE_BITS'(1);
      wcnt_q    <= '0;
      wlong_q   <= 1'b0;
      pend_q    <= '0;
      phase_q   <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      if (commit) begin
        mode_q    <= mode_d;
        off_q     <= off_d;
        line_q    <= line_d;
        col_q     <= col_d;
        ts_off_q  <= ts_off_d;
        ts_line_q <= ts_line_d;
        ts_col_q  <= ts_col_d;
        wcnt_q    <= wcnt_d;
        wlong_q   <= wlong_d;
        pend_q    <= pend_d;
      end
      if (beat_valid_i && can_out && ntok == 2'd2) phase_q <= !phase_q;
      if (can_out) out_v_q <= beat_valid_i && (ntok != 2'd0);
    end
  end

  // Store word bytes
  always_ff @(posedge clk_i) begin
    if (commit && wwr) wbuf_q[widx] <= beat_i.data;
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (can_out && beat_valid_i && ntok != 2'd0) begin
      out_q  <= (ntok == 2'd2 && phase_q) ? tk1 : tk0;
      last_q <= (ntok != 2'd2) || phase_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign token_kind_o   = out_q.kind;
  assign start_offset_o = out_q.off;
  assign token_length_o = out_q.len;
  assign start_line_o   = out_q.line;
  assign start_column_o = out_q.col;
  assign last_of_run_o  = last_q;

endmodule

/* rtl/source_tokenizer.sv */
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming lexer: source bytes in, tokens with position and length out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | beat
//  in      | input     | in_valid_i / in_stall_o  | byte_value_i, end_of_input_i
//  out     | output    | out_valid_o / out_stall_i| token_kind_o .. last_of_run_o
//
// One source byte per cycle while neither side stalls; a byte that ends a
// token and also yields a single-character token (operator, punctuation or
// error) or end of file occupies the scan engine for a second pass. A beat is
// written into the queue, then scanned into the output register.
// A four-beat queue separates the classifier from the scan engine.
// Reset (async, active low) restores line and column 1, offset 0, idle mode.
// ----------------------------------------------------------------------------
module source_tokenizer import stok_pkg::*; #(
  parameter int OFFSET_BITS     = OFFSET_BITS_DEF,
  parameter int LINE_BITS       = LINE_BITS_DEF,
  parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             byte_value_i,
  input  logic                   end_of_input_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [KIND_W-1:0]      token_kind_o,
  output logic [OFFSET_BITS-1:0] start_offset_o,
  output logic [OFFSET_BITS-1:0] token_length_o,
  output logic [LINE_BITS-1:0]   start_line_o,
  output logic [LINE_BITS-1:0]   start_column_o,
  output logic                   last_of_run_o
);

  logic  beat_valid, beat_pop;
  beat_t beat;

  stok_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .byte_value_i   (byte_value_i),
    .end_of_input_i (end_of_input_i),
    .beat_valid_o   (beat_valid),
    .beat_o         (beat),
    .beat_pop_i     (beat_pop)
  );

  stok_back #(
    .OFFSET_BITS     (OFFSET_BITS),
    .LINE_BITS       (LINE_BITS),
    .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .beat_valid_i   (beat_valid),
    .beat_i         (beat),
    .beat_pop_o     (beat_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .start_offset_o (start_offset_o),
    .token_length_o (token_length_o),
    .start_line_o   (start_line_o),
    .start_column_o (start_column_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

/* sim/stok_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stok_checker
// Watches both channels of the tokenizer. Every accepted source byte runs
// through a local lexer model whose tokens wait in a queue. Each output beat
// is compared field by field with the oldest waiting token.
// ----------------------------------------------------------------------------
module stok_checker import stok_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [7:0]        byte_value_i,
  input  logic              end_of_input_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [KIND_W-1:0] token_kind_i,
  input  logic [23:0]       start_offset_i,
  input  logic [23:0]       token_length_i,
  input  logic [15:0]       start_line_i,
  input  logic [15:0]       start_column_i,
  input  logic              last_of_run_i,
  output int                pending_o,
  output int                errors_o
);

  localparam longint OFF_TOP  = (64'd1 << 24) - 1;
  localparam longint LINE_TOP = (64'd1 << 16) - 1;

  typedef enum int {
    LX_IDLE, LX_INT, LX_FRAC, LX_WORD, LX_STR, LX_ESC, LX_CMT, LX_OP
  } lex_mode_e;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [23:0]       off;
    logic [23:0]       len;
    logic [15:0]       line;
    logic [15:0]       col;
    logic              last;
  } token_t;

  string keyword_names [KW_COUNT] = '{
    "inicio", "var", "def", "retorna", "se", "senao", "enquanto", "para",
    "escreve", "le", "inteiro", "decimal", "texto", "logico", "verdadeiro",
    "falso", "e", "ou", "nao"
  };

  token_t    token_q [$];
  lex_mode_e mode;
  longint    pos, line, col, tok_pos, tok_line, tok_col;
  logic [7:0] word_bytes [KEYWORD_MAX_LEN_DEF];
  int        word_cnt;
  bit        word_long;
  logic [7:0] held_op;
  int        step_cnt;
  int        errors;

  assign pending_o = token_q.size();
  assign errors_o  = errors;

  task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
    $display("%0t mismatch %s: expected %0d got %0d", $time, what, exp_v, got_v);
    errors++;
  endtask

  // Append one token of this step; at most two per step
  function automatic void emit(input logic [KIND_W-1:0] k, input longint o, input longint l,
                               input longint ln, input longint c);
    token_t t;
    if (step_cnt >= 2) return;
    t.kind = k; t.off = o[23:0]; t.len = l[23:0];
    t.line = ln[15:0]; t.col = c[15:0]; t.last = 1'b0;
    token_q.insert(token_q.size(), t);
    step_cnt++;
  endfunction

  function automatic void emit_started(input logic [KIND_W-1:0] k, input longint l);
    emit(k, tok_pos, l, tok_line, tok_col);
  endfunction

  function automatic void mark_token();
    tok_pos = pos; tok_line = line; tok_col = col;
  endfunction

  function automatic logic [KIND_W-1:0] keyword_or_ident();
    bit hit;
    if (word_long) return KIND_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      hit = (keyword_names[k].len() == word_cnt);
      for (int i = 0; hit && i < word_cnt; i++)
        if (keyword_names[k][i] != word_bytes[i]) hit = 0;
      if (hit) return k[KIND_W-1:0];
    end
    return KIND_IDENT;
  endfunction

  function automatic void keep_word_byte(input logic [7:0] b);
    if (word_cnt < KEYWORD_MAX_LEN_DEF) begin
      word_bytes[word_cnt] = b;
      word_cnt++;
    end else begin
      word_long = 1;
    end
  endfunction

  function automatic logic [KIND_W-1:0] op_kind(input logic [7:0] c);
    case (c)
      "+": return KIND_PLUS;   "-": return KIND_MINUS;  "*": return KIND_STAR;
      "/": return KIND_SLASH;  "%": return KIND_PERCENT; "=": return KIND_ASSIGN;
      "<": return KIND_LT;     ">": return KIND_GT;     ":": return KIND_COLON;
      ",": return KIND_COMMA;  "(": return KIND_LPAREN; ")": return KIND_RPAREN;
      "{": return KIND_LBRACE; "}": return KIND_RBRACE;
      default: return KIND_ERR;
    endcase
  endfunction

  function automatic bit is_num(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  // Run one source beat through the lexer model
  function automatic void lex_beat(input logic [7:0] b, input logic eoi);
    bit used, open_str, paired;
    logic [KIND_W-1:0] pk;
    int first;
    used = 0; open_str = 0; paired = 0; pk = KIND_ERR;
    step_cnt = 0;
    first = token_q.size();
    if (eoi) begin
      // flush what is in progress, then end of file
      case (mode)
        LX_INT:         emit_started(KIND_INT, pos - tok_pos);
        LX_FRAC:        emit_started(KIND_DEC, pos - tok_pos);
        LX_WORD:        emit_started(keyword_or_ident(), pos - tok_pos);
        LX_STR, LX_ESC: emit_started(KIND_OPEN_STR, pos - tok_pos);
        LX_OP:          emit_started(op_kind(held_op), 1);
        default: ;
      endcase
      mode = LX_IDLE;
      emit(KIND_EOF, pos, 0, line, col);
    end else begin
      case (mode)
        LX_INT: begin
          if (is_num(b)) used = 1;
          else if (b == ".") begin mode = LX_FRAC; used = 1; end
          else begin emit_started(KIND_INT, pos - tok_pos); mode = LX_IDLE; end
        end
        LX_FRAC: begin
          if (is_num(b)) used = 1;
          else begin emit_started(KIND_DEC, pos - tok_pos); mode = LX_IDLE; end
        end
        LX_WORD: begin
          if (is_letter(b) || is_num(b) || b == "_") begin
            keep_word_byte(b);
            used = 1;
          end else begin
            emit_started(keyword_or_ident(), pos - tok_pos);
            mode = LX_IDLE;
          end
        end
        LX_STR: begin
          if (b == "\"") begin emit_started(KIND_STR, pos - tok_pos); mode = LX_IDLE; end
          else if (b == "\\") mode = LX_ESC;
          used = 1;
        end
        LX_ESC: begin mode = LX_STR; used = 1; end
        LX_CMT: begin
          if (b == "\n") mode = LX_IDLE;
          used = 1;
        end
        LX_OP: begin
          if (b == "=" && (held_op == "=" || held_op == "!" || held_op == "<" ||
                           held_op == ">")) begin
            paired = 1;
            pk = (held_op == "=") ? KIND_EQ : (held_op == "!") ? KIND_NE :
                 (held_op == "<") ? KIND_LE : KIND_GE;
          end else if (held_op == "&" && b == "&") begin
            paired = 1; pk = KIND_AND;
          end else if (held_op == "|" && b == "|") begin
            paired = 1; pk = KIND_OR;
          end
          if (paired) begin
            emit_started(pk, 2); mode = LX_IDLE; used = 1;
          end else if (held_op == "/" && b == "/") begin
            mode = LX_CMT; used = 1;
          end else begin
            emit_started(op_kind(held_op), 1); mode = LX_IDLE;
          end
        end
        default: mode = LX_IDLE;
      endcase

      // start a new token with this byte
      if (!used) begin
        if (b == " " || b == "\t" || b == "\r" || b == "\n") begin
        end else if (is_num(b)) begin
          mark_token(); mode = LX_INT;
        end else if (is_letter(b) || b == "_") begin
          mark_token(); word_cnt = 0; word_long = 0;
          keep_word_byte(b); mode = LX_WORD;
        end else if (b == "\"") begin
          open_str = 1;
        end else if (b == "=" || b == "!" || b == "<" || b == ">" ||
                     b == "&" || b == "|" || b == "/") begin
          mark_token(); held_op = b; mode = LX_OP;
        end else begin
          emit(op_kind(b), pos, 1, line, col);
        end
      end

      // advance position with saturation
      if (pos < OFF_TOP) pos++;
      if (b == "\n") begin
        if (line < LINE_TOP) line++;
        col = 1;
      end else if (col < LINE_TOP) begin
        col++;
      end
      if (open_str) begin mark_token(); mode = LX_STR; end
    end
    if (token_q.size() > first) token_q[token_q.size()-1].last = 1'b1;
  endfunction

  // Predict on input beats, compare on output beats
  always @(posedge clk_i or negedge rst_ni) begin
    token_t t;
    if (!rst_ni) begin
      mode = LX_IDLE; pos = 0; line = 1; col = 1;
      tok_pos = 0; tok_line = 1; tok_col = 1;
      word_cnt = 0; word_long = 0; held_op = 8'h00;
      token_q.delete();
      errors = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (token_q.size() == 0) begin
          report_mismatch("token with none expected, kind", -1, token_kind_i);
        end else begin
          t = token_q.pop_front();
          if (token_kind_i !== t.kind) report_mismatch("kind", t.kind, token_kind_i);
          if (start_offset_i !== t.off) report_mismatch("offset", t.off, start_offset_i);
          if (token_length_i !== t.len) report_mismatch("length", t.len, token_length_i);
          if (start_line_i !== t.line) report_mismatch("line", t.line, start_line_i);
          if (start_column_i !== t.col) report_mismatch("column", t.col, start_column_i);
          if (last_of_run_i !== t.last) report_mismatch("last", t.last, last_of_run_i);
        end
      end
      if (in_valid_i && !in_stall_i) lex_beat(byte_value_i, end_of_input_i);
    end
  end

endmodule

/* sim/tb_source_tokenizer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_source_tokenizer
// Feeds the tokenizer with directed and random source text under several
// sender/receiver idle mixes; the checker beside the block predicts and
// compares every token.
// ----------------------------------------------------------------------------
module tb_source_tokenizer;
  import stok_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [7:0]        byte_value_i = 8'h00;
  logic              end_of_input_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [KIND_W-1:0] token_kind_o;
  logic [23:0]       start_offset_o;
  logic [23:0]       token_length_o;
  logic [15:0]       start_line_o;
  logic [15:0]       start_column_o;
  logic              last_of_run_o;
  int                pending, errors;
  int                send_idle_pct = 0;
  int                stall_pct = 0;

  typedef struct {
    logic [7:0] b;
    logic       eoi;
  } src_beat_t;

  src_beat_t src_q [$];

  string keyword_list [19] = '{
    "inicio", "var", "def", "retorna", "se", "senao", "enquanto", "para",
    "escreve", "le", "inteiro", "decimal", "texto", "logico", "verdadeiro",
    "falso", "e", "ou", "nao"
  };
  string op_list [23] = '{
    "+", "-", "*", "/", "%", "=", "<", ">", ":", ",", "(", ")", "{", "}",
    "==", "!=", "<=", ">=", "&&", "||", "!", "&", "|"
  };

  always #6 clk_i = ~clk_i;

  source_tokenizer dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .byte_value_i, .end_of_input_i,
    .out_valid_o, .out_stall_i, .token_kind_o, .start_offset_o, .token_length_o,
    .start_line_o, .start_column_o, .last_of_run_o
  );

  stok_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .byte_value_i,
    .end_of_input_i, .out_valid_i(out_valid_o), .out_stall_i,
    .token_kind_i(token_kind_o), .start_offset_i(start_offset_o),
    .token_length_i(token_length_o), .start_line_i(start_line_o),
    .start_column_i(start_column_o), .last_of_run_i(last_of_run_o),
    .pending_o(pending), .errors_o(errors)
  );

  // Random receiver backpressure
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  function automatic void add_text(input string s);
    src_beat_t e;
    for (int i = 0; i < s.len(); i++) begin
      e.b = s[i]; e.eoi = 1'b0;
      src_q.insert(src_q.size(), e);
    end
  endfunction

  function automatic void add_byte(input logic [7:0] b, input logic eoi);
    src_beat_t e;
    e.b = b; e.eoi = eoi;
    src_q.insert(src_q.size(), e);
  endfunction

  function automatic logic [7:0] word_char(input bit first);
    int r;
    r = $urandom_range(first ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62 && !first) return 8'("0" + r - 52);
    return "_";
  endfunction

  // Queue one random fragment of source text
  function automatic void add_fragment();
    int n;
    case ($urandom_range(11))
      0: add_text(keyword_list[$urandom_range(18)]);
      1: begin
        n = $urandom_range(14);
        add_byte(word_char(1), 0);
        repeat (n) add_byte(word_char(0), 0);
      end
      2: repeat ($urandom_range(1, 5)) add_byte(8'("0" + $urandom_range(9)), 0);
      3: begin
        repeat ($urandom_range(1, 3)) add_byte(8'("0" + $urandom_range(9)), 0);
        add_text(".");
        repeat ($urandom_range(0, 3)) add_byte(8'("0" + $urandom_range(9)), 0);
        if ($urandom_range(3) == 0) add_text(".5");
      end
      4: begin
        add_text("\"");
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(4) == 0) add_text("\\");
          add_byte(($urandom_range(3) == 0) ? 8'("\"") : 8'($urandom_range(32, 126)), 0);
        end
        add_text("\"");
      end
      5, 6: add_text(op_list[$urandom_range(22)]);
      7: begin
        add_text("//");
        repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(32, 126)), 0);
        add_text("\n");
      end
      8: add_byte(8'($urandom_range(255)), 0);
      9: add_byte(8'($urandom_range(255)), 1);
      default: begin
        case ($urandom_range(3))
          0: add_text(" ");
          1: add_text("\t");
          2: add_text("\r\n");
          default: add_text("\n");
        endcase
      end
    endcase
    if ($urandom_range(2) == 0) add_text(" ");
  endfunction

  // Drive queued beats; idle between beats at the sender's rate
  task automatic send_all();
    src_beat_t e;
    while (src_q.size() > 0) begin
      e = src_q.pop_front();
      @(negedge clk_i);
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid_i     <= 1'b0;
        byte_value_i   <= 8'($urandom);
        end_of_input_i <= 1'($urandom);
        @(negedge clk_i);
      end
      in_valid_i     <= 1'b1;
      byte_value_i   <= e.b;
      end_of_input_i <= e.eoi;
      do @(posedge clk_i); while (in_stall_o);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic random_phase(input int sender, input int receiver, input int items);
    send_idle_pct = sender;
    stall_pct     = receiver;
    while (src_q.size() < items) add_fragment();
    add_byte(8'h00, 1);
    send_all();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: keywords, numbers, pairs, lone starts, odd bytes, open string
    add_text("se x1==2.5.< \"a\\\"\"!&|");
    add_byte(8'h00, 0);
    add_byte(8'hFF, 0);
    add_text("abcdefghijkl \"op");
    add_byte(8'h00, 1);
    add_text("//c");
    add_byte(8'h00, 1);
    send_all();

    random_phase(0, 0, 400);
    random_phase(60, 0, 400);
    random_phase(0, 60, 400);
    random_phase(37, 37, 400);

    wait (pending == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb_source_tokenizer: clean");
    end else begin
      $display("tb_source_tokenizer: errors");
    end
    $finish;
  end

  // Hard stop on a hung run
  initial begin
    #(64'd20_000_000);
    $display("tb_source_tokenizer: errors");
    $finish;
  end

endmodule
